FILE: sv/crf_pkg.sv
// Shared types and codes for the rectangle fill and keyed copy block.
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

  // Clipped edge coordinate: signed, wide enough for -2048..2048.
  typedef logic signed [12:0] coord_t;

  // Operation codes carried on in_func.
  localparam logic [2:0] FUNC_FILL  = 3'd0;
  localparam logic [2:0] FUNC_DEST  = 3'd1;
  localparam logic [2:0] FUNC_SRC   = 3'd2;
  localparam logic [2:0] FUNC_PIXEL = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Largest value the result field holds.
  localparam logic [18:0] VALUE_MAX = 19'h7FFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_BASE,
    ST_FILL_RUN,
    ST_COPY_SIZE,
    ST_COPY_COUNT,
    ST_COPY_EMIT,
    ST_READ_ADDR,
    ST_READ_MEM,
    ST_READ_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic fill_base;
    logic fill_step;
    logic copy_size;
    logic copy_count;
    logic emit_count;
    logic read_addr;
    logic read_mem;
    logic emit_read;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic fill_empty;
    logic fill_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/crf_ctrl.sv
// Operation sequencer for the rectangle fill and keyed copy block.
`timescale 1ns / 1ps
`default_nettype none

module crf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           func,
  input  crf_pkg::dp_status_t  status,
  output logic                 busy,
  output crf_pkg::dp_cmd_t     cmd
);
  import crf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (func == FUNC_FILL) begin
            state_nxt = ST_FILL_BASE;
          end else if (func == FUNC_SRC) begin
            state_nxt = ST_COPY_SIZE;
          end else if (func == FUNC_READ) begin
            state_nxt = ST_READ_ADDR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FILL_BASE: begin
        state_nxt = status.fill_empty ? ST_IDLE : ST_FILL_RUN;
      end
      ST_FILL_RUN: begin
        if (status.fill_done) state_nxt = ST_IDLE;
      end
      ST_COPY_SIZE:  state_nxt = ST_COPY_COUNT;
      ST_COPY_COUNT: state_nxt = ST_COPY_EMIT;
      ST_COPY_EMIT:  state_nxt = ST_IDLE;
      ST_READ_ADDR:  state_nxt = ST_READ_MEM;
      ST_READ_MEM:   state_nxt = ST_READ_EMIT;
      ST_READ_EMIT:  state_nxt = ST_IDLE;
      default:       state_nxt = ST_CLEAR;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    unique case (state_r)
      ST_CLEAR:      cmd.clear_step = 1'b1;
      ST_IDLE:       ;
      ST_FILL_BASE:  cmd.fill_base  = 1'b1;
      ST_FILL_RUN:   cmd.fill_step  = 1'b1;
      ST_COPY_SIZE:  cmd.copy_size  = 1'b1;
      ST_COPY_COUNT: cmd.copy_count = 1'b1;
      ST_COPY_EMIT:  cmd.emit_count = 1'b1;
      ST_READ_ADDR:  cmd.read_addr  = 1'b1;
      ST_READ_MEM:   cmd.read_mem   = 1'b1;
      ST_READ_EMIT:  cmd.emit_read  = 1'b1;
      default:       ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/crf_datapath.sv
// Frame store, window registers, address walkers and result register.
`timescale 1ns / 1ps
`default_nettype none

module crf_datapath #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  crf_pkg::dp_cmd_t         cmd,
  output crf_pkg::dp_status_t      status,
  input  logic [2:0]               in_func,
  input  logic                     in_rect_given,
  input  logic signed [11:0]       in_rect_left,
  input  logic signed [11:0]       in_rect_top,
  input  logic signed [11:0]       in_rect_right,
  input  logic signed [11:0]       in_rect_bottom,
  input  logic [7:0]               in_pixel_value,
  input  logic                     in_key_enable,
  input  logic [10:0]              in_source_width,
  input  logic [10:0]              in_source_height,
  output logic                     out_valid,
  output logic                     out_result_kind,
  output logic [18:0]              out_result_value
);
  import crf_pkg::*;

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int PW  = AW + 12;
  localparam logic [AW-1:0] W_A    = AW'(FRAME_WIDTH);
  localparam logic [AW-1:0] LAST_A = AW'(PIX - 1);
  localparam coord_t        W_C    = coord_t'(FRAME_WIDTH);
  localparam coord_t        H_C    = coord_t'(FRAME_HEIGHT);

  function automatic coord_t sx(input logic signed [11:0] v);
    return {v[11], v};
  endfunction

  function automatic coord_t lo_clip(input logic signed [11:0] v);
    coord_t s;
    s = sx(v);
    return (s < 13'sd0) ? '0 : s;
  endfunction

  function automatic coord_t hi_clip(input logic signed [11:0] v, input coord_t lim);
    coord_t s;
    s = sx(v);
    return (s > lim) ? lim : s;
  endfunction

  function automatic logic [11:0] span(input coord_t lo, input coord_t hi, input coord_t slo,
                                       input coord_t shi);
    logic signed [13:0] d;
    logic signed [13:0] s;
    logic signed [13:0] m;
    d = {hi[12], hi} - {lo[12], lo};
    s = {shi[12], shi} - {slo[12], slo};
    m = (d < s) ? d : s;
    return (m <= 14'sd0) ? 12'd0 : m[11:0];
  endfunction

  // Frame store and write port
  logic [7:0]    frame_mem_r [PIX];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // Clear pass
  logic [AW-1:0] clr_addr_r;

  // Fill walker
  coord_t        fl_left_r, fl_top_r, fl_right_r, fl_bottom_r;
  logic [7:0]    fill_color_r;
  coord_t        fx_r, fy_r;
  logic [AW-1:0] fill_addr_r, fill_row_r;
  logic [PW-1:0] fill_prod;
  logic          fill_x_end;

  // Copy state
  coord_t        dst_left_r, dst_top_r, dst_right_r, dst_bottom_r;
  coord_t        src_left_r, src_top_r, src_right_r, src_bottom_r;
  logic          key_on_r;
  logic [7:0]    key_val_r;
  logic [11:0]   copy_w_r, copy_h_r;
  logic [11:0]   cur_x_r, cur_y_r;
  logic          copy_active_r;
  logic [AW-1:0] ptr_r, row_r;
  logic [PW-1:0] dst_prod;
  logic [11:0]   size_w, size_h;
  logic [23:0]   count_r;
  logic          pix_beat;
  logic          pix_write;

  // Read path
  logic [10:0]   rd_x_r, rd_y_r;
  logic          rd_ok_r;
  logic [AW-1:0] rd_addr_r;
  logic [PW-1:0] rd_prod;
  logic [7:0]    rdata_r;
  coord_t        rx, ry;

  // Result register
  logic          out_valid_r;
  logic          out_kind_r;
  logic [18:0]   out_value_r;

  assign fill_prod = PW'(fl_top_r[10:0]) * PW'(FRAME_WIDTH) + PW'(fl_left_r[10:0]);
  assign dst_prod  = PW'(dst_top_r[10:0]) * PW'(FRAME_WIDTH) + PW'(dst_left_r[10:0]);
  assign rd_prod   = PW'(rd_y_r) * PW'(FRAME_WIDTH) + PW'(rd_x_r);
  assign size_w    = span(dst_left_r, dst_right_r, src_left_r, src_right_r);
  assign size_h    = span(dst_top_r, dst_bottom_r, src_top_r, src_bottom_r);
  assign rx        = sx(in_rect_left);
  assign ry        = sx(in_rect_top);

  // Status to the controller
  assign fill_x_end        = (coord_t'(fx_r + 13'sd1) == fl_right_r);
  assign status.clear_last = (clr_addr_r == LAST_A);
  assign status.fill_empty = (fl_right_r <= fl_left_r) || (fl_bottom_r <= fl_top_r);
  assign status.fill_done  = fill_x_end && (coord_t'(fy_r + 13'sd1) == fl_bottom_r);

  // Source pixel beat: lands unless it matches the enabled key
  assign pix_beat  = cmd.accept && (in_func == FUNC_PIXEL) && copy_active_r;
  assign pix_write = pix_beat && !(key_on_r && (in_pixel_value == key_val_r));

  // Write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    priority if (cmd.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
    end else if (cmd.fill_step) begin
      mem_we = 1'b1;
      mem_wa = fill_addr_r;
      mem_wd = fill_color_r;
    end else if (pix_write) begin
      mem_we = 1'b1;
      mem_wa = ptr_r;
      mem_wd = in_pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem_r[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.read_mem) rdata_r <= frame_mem_r[rd_addr_r];
  end

  // Clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Fill capture and walk
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == FUNC_FILL)) begin
      fill_color_r <= in_pixel_value;
      if (in_rect_given) begin
        fl_left_r   <= lo_clip(in_rect_left);
        fl_top_r    <= lo_clip(in_rect_top);
        fl_right_r  <= hi_clip(in_rect_right, W_C);
        fl_bottom_r <= hi_clip(in_rect_bottom, H_C);
      end else begin
        fl_left_r   <= '0;
        fl_top_r    <= '0;
        fl_right_r  <= W_C;
        fl_bottom_r <= H_C;
      end
    end
    if (cmd.fill_base) begin
      fill_addr_r <= fill_prod[AW-1:0];
      fill_row_r  <= fill_prod[AW-1:0];
      fx_r        <= fl_left_r;
      fy_r        <= fl_top_r;
    end else if (cmd.fill_step) begin
      if (fill_x_end) begin
        fx_r        <= fl_left_r;
        fy_r        <= coord_t'(fy_r + 13'sd1);
        fill_row_r  <= fill_row_r + W_A;
        fill_addr_r <= fill_row_r + W_A;
      end else begin
        fx_r        <= coord_t'(fx_r + 13'sd1);
        fill_addr_r <= fill_addr_r + AW'(1);
      end
    end
  end

  // Copy windows, size and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_left_r    <= '0;
      dst_top_r     <= '0;
      dst_right_r   <= '0;
      dst_bottom_r  <= '0;
      key_on_r      <= 1'b0;
      key_val_r     <= '0;
      copy_w_r      <= '0;
      copy_h_r      <= '0;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      copy_active_r <= 1'b0;
      ptr_r         <= '0;
      row_r         <= '0;
    end else begin
      if (cmd.accept && (in_func == FUNC_DEST)) begin
        if (in_rect_given) begin
          dst_left_r   <= lo_clip(in_rect_left);
          dst_top_r    <= lo_clip(in_rect_top);
          dst_right_r  <= hi_clip(in_rect_right, W_C);
          dst_bottom_r <= hi_clip(in_rect_bottom, H_C);
        end else begin
          dst_left_r   <= '0;
          dst_top_r    <= '0;
          dst_right_r  <= W_C;
          dst_bottom_r <= H_C;
        end
        copy_active_r <= 1'b0;
        copy_w_r      <= '0;
        copy_h_r      <= '0;
        cur_x_r       <= '0;
        cur_y_r       <= '0;
      end
      if (cmd.accept && (in_func == FUNC_SRC)) begin
        key_on_r  <= in_key_enable;
        key_val_r <= in_pixel_value;
      end
      if (cmd.copy_size) begin
        copy_w_r      <= size_w;
        copy_h_r      <= size_h;
        cur_x_r       <= '0;
        cur_y_r       <= '0;
        ptr_r         <= dst_prod[AW-1:0];
        row_r         <= dst_prod[AW-1:0];
        copy_active_r <= (size_w != 12'd0) && (size_h != 12'd0);
      end
      // Advance one pixel per source beat, row by row
      if (pix_beat) begin
        if (12'(cur_x_r + 12'd1) == copy_w_r) begin
          cur_x_r <= '0;
          ptr_r   <= row_r + W_A;
          row_r   <= row_r + W_A;
          if (12'(cur_y_r + 12'd1) == copy_h_r) begin
            copy_active_r <= 1'b0;
          end else begin
            cur_y_r <= 12'(cur_y_r + 12'd1);
          end
        end else begin
          cur_x_r <= 12'(cur_x_r + 12'd1);
          ptr_r   <= ptr_r + AW'(1);
        end
      end
    end
  end

  // Source window capture, clipped to the source surface
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == FUNC_SRC)) begin
      if (in_rect_given) begin
        src_left_r   <= lo_clip(in_rect_left);
        src_top_r    <= lo_clip(in_rect_top);
        src_right_r  <= hi_clip(in_rect_right, coord_t'({2'b00, in_source_width}));
        src_bottom_r <= hi_clip(in_rect_bottom, coord_t'({2'b00, in_source_height}));
      end else begin
        src_left_r   <= '0;
        src_top_r    <= '0;
        src_right_r  <= coord_t'({2'b00, in_source_width});
        src_bottom_r <= coord_t'({2'b00, in_source_height});
      end
    end
    if (cmd.copy_count) count_r <= 24'(copy_w_r) * 24'(copy_h_r);
  end

  // Read capture and address
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == FUNC_READ)) begin
      rd_x_r  <= in_rect_left[10:0];
      rd_y_r  <= in_rect_top[10:0];
      rd_ok_r <= (rx >= 13'sd0) && (rx < W_C) && (ry >= 13'sd0) && (ry < H_C);
    end
    if (cmd.read_addr) rd_addr_r <= rd_prod[AW-1:0];
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_count || cmd.emit_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_count) begin
      out_kind_r  <= KIND_COUNT;
      out_value_r <= (count_r > 24'(VALUE_MAX)) ? VALUE_MAX : count_r[18:0];
    end else if (cmd.emit_read) begin
      out_kind_r  <= KIND_PIXEL;
      out_value_r <= rd_ok_r ? 19'(rdata_r) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_value_r;

endmodule

`default_nettype wire

FILE: sv/clipped_rect_fill_and_keyed_copy_core.sv
// Top level of the 8-bit frame store with rectangle fill, keyed copy and read.
//
// Usage:
//   Input: an item is taken on a clock edge with start high and busy low.
//     in_func selects fill, copy destination window, copy source window,
//     source pixel or read. Codes 5..7 are taken and ignored.
//   Result: out_valid strobes for one cycle with out_result_kind and
//     out_result_value; there is no back-pressure on this side.
// Timing:
//   Source pixel, destination window and ignored items leave busy low,
//     so source pixels stream at one beat per cycle.
//   Fill: busy for a setup state, then writes one pixel of the clipped
//     rectangle per cycle (single write port of the frame store).
//   Copy source window and read: busy until the emit state; the result
//     strobes in the first cycle with busy low.
// Reset:
//   Synchronous, active low. After reset a clearing pass writes zero to
//   every pixel, one per cycle, with busy high; destination window,
//   cursor and key registers reset to zero and key disabled.
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_and_keyed_copy_core #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic               in_rect_given,
  input  logic signed [11:0] in_rect_left,
  input  logic signed [11:0] in_rect_top,
  input  logic signed [11:0] in_rect_right,
  input  logic signed [11:0] in_rect_bottom,
  input  logic [7:0]         in_pixel_value,
  input  logic               in_key_enable,
  input  logic [10:0]        in_source_width,
  input  logic [10:0]        in_source_height,
  output logic               out_valid,
  output logic               out_result_kind,
  output logic [18:0]        out_result_value
);
  import crf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  crf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func   (in_func),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  crf_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_func          (in_func),
    .in_rect_given    (in_rect_given),
    .in_rect_left     (in_rect_left),
    .in_rect_top      (in_rect_top),
    .in_rect_right    (in_rect_right),
    .in_rect_bottom   (in_rect_bottom),
    .in_pixel_value   (in_pixel_value),
    .in_key_enable    (in_key_enable),
    .in_source_width  (in_source_width),
    .in_source_height (in_source_height),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value)
  );

  // Reset always leads into the clearing pass
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // A result beat never lasts more than one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");

  // Read answers with pixel data after its address, memory and emit states
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_READ)) |-> ##4
      (out_valid && (out_result_kind == KIND_PIXEL)))
    else $error("read result missing");

  // Copy setup answers with a count after its size, count and emit states
  a_count_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_SRC)) |-> ##4
      (out_valid && (out_result_kind == KIND_COUNT)))
    else $error("copy count missing");

endmodule

`default_nettype wire
